### rtl/elu_pkg.sv
// Shared constants and pipeline word types for the eikonal local update unit.
package elu_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int SPEED_BITS    = 16;
  localparam int SPEED_FRAC    = 8;
  localparam int AXES          = 3;
  localparam int ROOT_BITS     = 25;
  localparam int RAD_BITS      = 2 * ROOT_BITS;
  localparam int E_BITS        = ROOT_BITS + 1;
  localparam int SQ_BITS       = 2 * E_BITS;
  localparam int PROD_BITS     = VALUE_BITS + SPEED_BITS;
  localparam int SUM_BITS      = VALUE_BITS + 2;
  localparam int T_BITS        = E_BITS + 1;
  localparam int ACC_BITS      = SQ_BITS + 2;
  localparam int DIV3_SHIFT    = 35;
  localparam int PRE_STAGES    = 7;
  localparam int POST_STAGES   = 3;
  localparam int LATENCY       = PRE_STAGES + 2 * ROOT_BITS + POST_STAGES;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  localparam logic [ACC_BITS-1:0]   DV_UNIT   =
    ACC_BITS'(1) << (2 * FRACTION_BITS + 2 * SPEED_FRAC);
  localparam logic [ROOT_BITS-1:0]  K1_NUM    =
    ROOT_BITS'(1) << (FRACTION_BITS + SPEED_FRAC);
  localparam logic [SUM_BITS-1:0]   DIV3_MUL  = SUM_BITS'(34'h2_AAAA_AAAB);

  typedef struct packed {
    logic [VALUE_BITS-1:0] cur;
    logic [1:0]            n;
    logic                  vzero;
    logic [SPEED_BITS-1:0] v;
    logic [SUM_BITS-1:0]   s1;
    logic [SUM_BITS-1:0]   s2;
    logic [SUM_BITS-1:0]   s3;
    logic [T_BITS-1:0]     t2;
    logic [T_BITS-1:0]     t3;
    logic                  neg2;
    logic                  neg3;
  } side_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] cur;
    logic [1:0]            n;
    logic [SUM_BITS-1:0]   s1;
    logic [SUM_BITS-1:0]   s2;
    logic [SUM_BITS-1:0]   s3;
    logic                  ok1;
    logic                  ok2;
    logic                  ok3;
  } tail_t;

endpackage

### rtl/eikonal_local_update_unit.sv
// Eikonal upwind local update: top level pipeline.
// Fully pipelined: a word is taken on every cycle that start is high (busy stays
// low), and its results appear on out_valid in the order the words were taken.
// The depth is set by the two bit-serial stages: a 25-stage square root and a
// 25-stage divider by the speed, plus ten stages of setup and selection. The
// receiver cannot stall, so nothing ever backs up.
module eikonal_local_update_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [elu_pkg::VALUE_BITS-1:0]  in_current_value,
  input  logic [elu_pkg::VALUE_BITS-1:0]  in_neighbor_minus_x,
  input  logic [elu_pkg::VALUE_BITS-1:0]  in_neighbor_plus_x,
  input  logic [elu_pkg::VALUE_BITS-1:0]  in_neighbor_minus_y,
  input  logic [elu_pkg::VALUE_BITS-1:0]  in_neighbor_plus_y,
  input  logic [elu_pkg::VALUE_BITS-1:0]  in_neighbor_minus_z,
  input  logic [elu_pkg::VALUE_BITS-1:0]  in_neighbor_plus_z,
  input  logic [elu_pkg::SPEED_BITS-1:0]  in_speed,
  output logic                            out_valid,
  output logic [elu_pkg::VALUE_BITS-1:0]  out_new_value,
  output logic                            out_improved,
  output logic [1:0]                      out_active_axes
);

  localparam int VB  = elu_pkg::VALUE_BITS;
  localparam int SB  = elu_pkg::SPEED_BITS;
  localparam int RB  = elu_pkg::ROOT_BITS;
  localparam int EB  = elu_pkg::E_BITS;
  localparam int QB  = elu_pkg::SQ_BITS;
  localparam int PB  = elu_pkg::PROD_BITS;
  localparam int UB  = elu_pkg::SUM_BITS;
  localparam int TB  = elu_pkg::T_BITS;
  localparam int AB  = elu_pkg::ACC_BITS;
  localparam int DB  = elu_pkg::RAD_BITS;
  localparam int LAT = elu_pkg::LATENCY;

  // valid bits
  logic vld_r [0:LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[LAT-1];

  // stage 0: input word
  logic [VB-1:0] cur0_r;
  logic [VB-1:0] nb0_r [0:5];
  logic [SB-1:0] v0_r;

  always_ff @(posedge clk) begin
    cur0_r   <= in_current_value;
    nb0_r[0] <= in_neighbor_minus_x;
    nb0_r[1] <= in_neighbor_plus_x;
    nb0_r[2] <= in_neighbor_minus_y;
    nb0_r[3] <= in_neighbor_plus_y;
    nb0_r[4] <= in_neighbor_minus_z;
    nb0_r[5] <= in_neighbor_plus_z;
    v0_r     <= in_speed;
  end

  // stage 1: upwind neighbor per axis
  logic [VB-1:0] smin1_r [0:2];
  logic [2:0]    act1_r;
  logic [VB-1:0] cur1_r;
  logic [SB-1:0] v1_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      smin1_r[i] <= (nb0_r[2*i] < nb0_r[2*i+1]) ? nb0_r[2*i] : nb0_r[2*i+1];
      act1_r[i]  <= ((nb0_r[2*i] < nb0_r[2*i+1]) ? nb0_r[2*i] : nb0_r[2*i+1]) < cur0_r;
    end
    cur1_r <= cur0_r;
    v1_r   <= v0_r;
  end

  // stage 2: sort, active ones first in ascending order
  logic [VB:0]   key_a, key_b, key_c, key_t;
  logic [VB-1:0] x2_r [0:2];
  logic [1:0]    n2_r;
  logic [VB-1:0] cur2_r;
  logic [SB-1:0] v2_r;

  always_comb begin
    key_t = '0;
    key_a = {~act1_r[0], smin1_r[0]};
    key_b = {~act1_r[1], smin1_r[1]};
    key_c = {~act1_r[2], smin1_r[2]};
    if (key_b < key_a) begin
      key_t = key_a; key_a = key_b; key_b = key_t;
    end
    if (key_c < key_b) begin
      key_t = key_b; key_b = key_c; key_c = key_t;
    end
    if (key_b < key_a) begin
      key_t = key_a; key_a = key_b; key_b = key_t;
    end
  end

  always_ff @(posedge clk) begin
    x2_r[0] <= key_a[VB-1:0];
    x2_r[1] <= key_b[VB-1:0];
    x2_r[2] <= key_c[VB-1:0];
    n2_r    <= 2'(act1_r[0]) + 2'(act1_r[1]) + 2'(act1_r[2]);
    cur2_r  <= cur1_r;
    v2_r    <= v1_r;
  end

  // stage 3: gaps and running sums
  logic [VB-1:0] d01_3_r, d12_3_r, d02_3_r;
  logic [UB-1:0] s1_3_r, s2_3_r, s3_3_r;
  logic [1:0]    n3_r;
  logic [VB-1:0] cur3_r;
  logic [SB-1:0] v3_r;

  always_ff @(posedge clk) begin
    d01_3_r <= x2_r[1] - x2_r[0];
    d12_3_r <= x2_r[2] - x2_r[1];
    d02_3_r <= x2_r[2] - x2_r[0];
    s1_3_r  <= UB'(x2_r[0]);
    s2_3_r  <= UB'(x2_r[0]) + UB'(x2_r[1]);
    s3_3_r  <= UB'(x2_r[0]) + UB'(x2_r[1]) + UB'(x2_r[2]);
    n3_r    <= n2_r;
    cur3_r  <= cur2_r;
    v3_r    <= v2_r;
  end

  // stage 4: scale gaps by speed
  logic [PB-1:0] e01_4_r, e12_4_r, e02_4_r;
  logic [UB-1:0] s1_4_r, s2_4_r, s3_4_r;
  logic [1:0]    n4_r;
  logic [VB-1:0] cur4_r;
  logic [SB-1:0] v4_r;

  always_ff @(posedge clk) begin
    e01_4_r <= PB'(v3_r) * PB'(d01_3_r);
    e12_4_r <= PB'(v3_r) * PB'(d12_3_r);
    e02_4_r <= PB'(v3_r) * PB'(d02_3_r);
    s1_4_r  <= s1_3_r;
    s2_4_r  <= s2_3_r;
    s3_4_r  <= s3_3_r;
    n4_r    <= n3_r;
    cur4_r  <= cur3_r;
    v4_r    <= v3_r;
  end

  // stage 5: squares; a large gap already makes the discriminant negative
  logic [QB-1:0] q01_5_r, q12_5_r, q02_5_r;
  logic          big01_5_r, bigany_5_r;
  logic [TB-1:0] t2_5_r, t3_5_r;
  logic [UB-1:0] s1_5_r, s2_5_r, s3_5_r;
  logic [1:0]    n5_r;
  logic [VB-1:0] cur5_r;
  logic [SB-1:0] v5_r;
  logic          big01, big12, big02;

  assign big01 = |e01_4_r[PB-1:EB];
  assign big12 = |e12_4_r[PB-1:EB];
  assign big02 = |e02_4_r[PB-1:EB];

  always_ff @(posedge clk) begin
    q01_5_r    <= QB'(e01_4_r[EB-1:0]) * QB'(e01_4_r[EB-1:0]);
    q12_5_r    <= QB'(e12_4_r[EB-1:0]) * QB'(e12_4_r[EB-1:0]);
    q02_5_r    <= QB'(e02_4_r[EB-1:0]) * QB'(e02_4_r[EB-1:0]);
    big01_5_r  <= big01;
    bigany_5_r <= big01 | big12 | big02;
    t2_5_r     <= TB'(e01_4_r[EB-1:0]);
    t3_5_r     <= TB'(e02_4_r[EB-1:0]) + TB'(e12_4_r[EB-1:0]);
    s1_5_r     <= s1_4_r;
    s2_5_r     <= s2_4_r;
    s3_5_r     <= s3_4_r;
    n5_r       <= n4_r;
    cur5_r     <= cur4_r;
    v5_r       <= v4_r;
  end

  // stage 6: discriminants for two and three axes
  logic [AB-1:0]        k2r, k3r, p2, p3;
  logic [DB-1:0]        dv2_6_r, dv3_6_r;
  elu_pkg::side_t       side6_r;

  assign k2r = elu_pkg::DV_UNIT << 1;
  assign k3r = (elu_pkg::DV_UNIT << 1) + elu_pkg::DV_UNIT;
  assign p2  = AB'(q01_5_r);
  assign p3  = AB'(q01_5_r) + AB'(q12_5_r) + AB'(q02_5_r);

  always_ff @(posedge clk) begin
    dv2_6_r       <= DB'(k2r - p2);
    dv3_6_r       <= DB'(k3r - p3);
    side6_r.cur   <= cur5_r;
    side6_r.n     <= n5_r;
    side6_r.vzero <= (v5_r == '0);
    side6_r.v     <= v5_r;
    side6_r.s1    <= s1_5_r;
    side6_r.s2    <= s2_5_r;
    side6_r.s3    <= s3_5_r;
    side6_r.t2    <= t2_5_r;
    side6_r.t3    <= t3_5_r;
    side6_r.neg2  <= big01_5_r | (k2r < p2);
    side6_r.neg3  <= bigany_5_r | (k3r < p3);
  end

  // square roots
  logic [RB-1:0] r2, r3;
  logic          nz2, nz3;

  elu_isqrt u_sqrt2 (.clk(clk), .in_rad(dv2_6_r), .out_root(r2), .out_rem_nz(nz2));
  elu_isqrt u_sqrt3 (.clk(clk), .in_rad(dv3_6_r), .out_root(r3), .out_rem_nz(nz3));

  elu_pkg::side_t side_d [0:RB-1];

  always_ff @(posedge clk) begin
    side_d[0] <= side6_r;
    for (int i = 1; i < RB; i++) side_d[i] <= side_d[i-1];
  end

  // candidate checks: real root must lie above the largest active time
  elu_pkg::side_t sq;
  elu_pkg::tail_t tail_c;
  logic [TB-1:0]  r2x, r3x;

  assign sq  = side_d[RB-1];
  assign r2x = TB'(r2);
  assign r3x = TB'(r3);

  always_comb begin
    tail_c.cur = sq.cur;
    tail_c.n   = sq.n;
    tail_c.s1  = sq.s1;
    tail_c.s2  = sq.s2;
    tail_c.s3  = sq.s3;
    tail_c.ok1 = !sq.vzero && (sq.n != 2'd0);
    tail_c.ok2 = !sq.vzero && (sq.n[1]) && !sq.neg2 &&
                 ((sq.t2 < r2x) || ((sq.t2 == r2x) && nz2));
    tail_c.ok3 = !sq.vzero && (sq.n == 2'd3) && !sq.neg3 &&
                 ((sq.t3 < r3x) || ((sq.t3 == r3x) && nz3));
  end

  // root / speed
  logic [RB-1:0] qo1, qo2, qo3;

  elu_div u_div1 (.clk(clk), .in_num(elu_pkg::K1_NUM), .in_den(sq.v), .out_quo(qo1));
  elu_div u_div2 (.clk(clk), .in_num(r2), .in_den(sq.v), .out_quo(qo2));
  elu_div u_div3 (.clk(clk), .in_num(r3), .in_den(sq.v), .out_quo(qo3));

  elu_pkg::tail_t tail_d [0:RB-1];

  always_ff @(posedge clk) begin
    tail_d[0] <= tail_c;
    for (int i = 1; i < RB; i++) tail_d[i] <= tail_d[i-1];
  end

  // stage A: numerators over k
  elu_pkg::tail_t ta;
  logic [UB-1:0]  xa1_r, xa2_r, xa3_r;
  logic [VB-1:0]  cura_r;
  logic [1:0]     na_r;
  logic [2:0]     oka_r;

  assign ta = tail_d[RB-1];

  always_ff @(posedge clk) begin
    xa1_r  <= ta.s1 + UB'(qo1);
    xa2_r  <= ta.s2 + UB'(qo2);
    xa3_r  <= ta.s3 + UB'(qo3);
    cura_r <= ta.cur;
    na_r   <= ta.n;
    oka_r  <= {ta.ok3, ta.ok2, ta.ok1};
  end

  // stage B: divide by k
  logic [2*UB-1:0] m3;
  logic [UB-1:0]   qb1_r, qb2_r, qb3_r;
  logic [VB-1:0]   curb_r;
  logic [1:0]      nb_r;
  logic [2:0]      okb_r;

  assign m3 = (2*UB)'(xa3_r) * (2*UB)'(elu_pkg::DIV3_MUL);

  always_ff @(posedge clk) begin
    qb1_r  <= xa1_r;
    qb2_r  <= xa2_r >> 1;
    qb3_r  <= UB'(m3 >> elu_pkg::DIV3_SHIFT);
    curb_r <= cura_r;
    nb_r   <= na_r;
    okb_r  <= oka_r;
  end

  // stage C: saturate and take the minimum
  logic [VB-1:0] c1, c2, c3, m_a, m_b, best;

  function automatic logic [VB-1:0] sat_cand(input logic ok, input logic [UB-1:0] q);
    logic [VB-1:0] res;
    res = elu_pkg::VALUE_MAX;
    if (ok && (q[UB-1:VB] == '0)) res = q[VB-1:0];
    return res;
  endfunction

  always_comb begin
    c1   = sat_cand(okb_r[0], qb1_r);
    c2   = sat_cand(okb_r[1], qb2_r);
    c3   = sat_cand(okb_r[2], qb3_r);
    m_a  = (c1 < curb_r) ? c1 : curb_r;
    m_b  = (c2 < c3) ? c2 : c3;
    best = (m_b < m_a) ? m_b : m_a;
  end

  logic [VB-1:0] new_value_r;
  logic          improved_r;
  logic [1:0]    active_r;

  always_ff @(posedge clk) begin
    new_value_r <= best;
    improved_r  <= best < curb_r;
    active_r    <= nb_r;
  end

  assign out_new_value   = new_value_r;
  assign out_improved    = improved_r;
  assign out_active_axes = active_r;

endmodule

### rtl/elu_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
module elu_isqrt (
  input  logic                           clk,
  input  logic [elu_pkg::RAD_BITS-1:0]   in_rad,
  output logic [elu_pkg::ROOT_BITS-1:0]  out_root,
  output logic                           out_rem_nz
);

  localparam int RB = elu_pkg::ROOT_BITS;
  localparam int DB = elu_pkg::RAD_BITS;
  localparam int WB = DB + 2;

  logic [RB-1:0] root_r [0:RB-1];
  logic [DB-1:0] rem_r  [0:RB-1];
  logic [RB-1:0] root_w [0:RB];
  logic [DB-1:0] rem_w  [0:RB];

  assign root_w[0] = '0;
  assign rem_w[0]  = in_rad;

  for (genvar g = 0; g < RB; g++) begin : g_stage
    localparam int B = RB - 1 - g;
    logic [WB-1:0] trial;
    logic [WB-1:0] rem_x;
    logic          ge;

    assign trial = (WB'(root_w[g]) << (B + 1)) + (WB'(1) << (2 * B));
    assign rem_x = WB'(rem_w[g]);
    assign ge    = rem_x >= trial;

    always_ff @(posedge clk) begin
      root_r[g] <= ge ? (root_w[g] | (RB'(1) << B)) : root_w[g];
      rem_r[g]  <= ge ? DB'(rem_x - trial) : rem_w[g];
    end

    assign root_w[g+1] = root_r[g];
    assign rem_w[g+1]  = rem_r[g];
  end

  assign out_root   = root_w[RB];
  assign out_rem_nz = |rem_w[RB];

endmodule

### rtl/elu_div.sv
// Pipelined restoring divider of a root or a constant by the speed, one quotient bit per stage.
module elu_div (
  input  logic                            clk,
  input  logic [elu_pkg::ROOT_BITS-1:0]   in_num,
  input  logic [elu_pkg::SPEED_BITS-1:0]  in_den,
  output logic [elu_pkg::ROOT_BITS-1:0]   out_quo
);

  localparam int RB = elu_pkg::ROOT_BITS;
  localparam int SB = elu_pkg::SPEED_BITS;

  logic [RB-1:0] num_r [0:RB-1];
  logic [SB-1:0] den_r [0:RB-1];
  logic [SB-1:0] rem_r [0:RB-1];
  logic [RB-1:0] quo_r [0:RB-1];
  logic [RB-1:0] num_w [0:RB];
  logic [SB-1:0] den_w [0:RB];
  logic [SB-1:0] rem_w [0:RB];
  logic [RB-1:0] quo_w [0:RB];

  assign num_w[0] = in_num;
  assign den_w[0] = in_den;
  assign rem_w[0] = '0;
  assign quo_w[0] = '0;

  for (genvar g = 0; g < RB; g++) begin : g_stage
    localparam int B = RB - 1 - g;
    logic [SB:0] part;
    logic [SB:0] den_x;
    logic        ge;

    assign part  = {rem_w[g], num_w[g][B]};
    assign den_x = {1'b0, den_w[g]};
    assign ge    = part >= den_x;

    always_ff @(posedge clk) begin
      num_r[g] <= num_w[g];
      den_r[g] <= den_w[g];
      rem_r[g] <= ge ? SB'(part - den_x) : part[SB-1:0];
      quo_r[g] <= ge ? (quo_w[g] | (RB'(1) << B)) : quo_w[g];
    end

    assign num_w[g+1] = num_r[g];
    assign den_w[g+1] = den_r[g];
    assign rem_w[g+1] = rem_r[g];
    assign quo_w[g+1] = quo_r[g];
  end

  assign out_quo = quo_w[RB];

endmodule

### verif/eikonal_local_update_unit_tb.sv
// Testbench for the eikonal local update unit: directed table plus random cells vs. a predictor.
module eikonal_local_update_unit_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int N_RANDOM   = 1100;
  localparam int VB         = elu_pkg::VALUE_BITS;
  localparam int SB         = elu_pkg::SPEED_BITS;
  localparam logic [VB-1:0] VMAX = elu_pkg::VALUE_MAX;

  typedef struct {
    logic [VB-1:0] cur;
    logic [VB-1:0] nb [6];
    logic [SB-1:0] v;
  } cell_t;

  typedef struct packed {
    logic [VB-1:0] new_value;
    logic          improved;
    logic [1:0]    axes;
  } upd_t;

  typedef struct {
    cell_t c;
    bit    typed;
    upd_t  r;
  } row_t;

  logic          clk = 0;
  logic          rst_n = 0;
  logic          start = 0;
  logic          busy;
  logic [VB-1:0] in_cur = '0;
  logic [VB-1:0] in_nb [6];
  logic [SB-1:0] in_speed = '0;
  logic          out_valid;
  logic [VB-1:0] out_new_value;
  logic          out_improved;
  logic [1:0]    out_active_axes;

  upd_t   pending_upd [$];
  upd_t   drive_upd;
  row_t   rows [$];
  int     errors = 0;
  int     accepted = 0;
  int     checked = 0;
  int     improved_seen = 0;
  int     idle = 0;
  int     axes_seen [4] = '{0, 0, 0, 0};

  initial foreach (in_nb[i]) in_nb[i] = '0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  eikonal_local_update_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_current_value(in_cur),
    .in_neighbor_minus_x(in_nb[0]), .in_neighbor_plus_x(in_nb[1]),
    .in_neighbor_minus_y(in_nb[2]), .in_neighbor_plus_y(in_nb[3]),
    .in_neighbor_minus_z(in_nb[4]), .in_neighbor_plus_z(in_nb[5]),
    .in_speed(in_speed),
    .out_valid(out_valid), .out_new_value(out_new_value),
    .out_improved(out_improved), .out_active_axes(out_active_axes)
  );

  // Exact upwind root over the active set; 0 when there is no candidate.
  function automatic bit upwind_root(input logic [VB-1:0] s [3], input bit act [3],
                                     input int k, input logic [VB-1:0] mx,
                                     input logic [SB-1:0] v,
                                     output logic [VB-1:0] root);
    bit [63:0]  sum;
    bit [127:0] p, kr, vp, dv, t, r, c, q, d;
    sum = 0;
    p = 0;
    r = 0;
    root = VMAX;
    if (v == 0) begin
      root = VMAX;
      return 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (!act[i]) continue;
      sum += 64'(s[i]);
      for (int j = i + 1; j < 3; j++) begin
        if (!act[j]) continue;
        d = (s[i] > s[j]) ? 128'(s[i] - s[j]) : 128'(s[j] - s[i]);
        p += d * d;
      end
    end
    kr = 128'(k) << (2 * elu_pkg::FRACTION_BITS + 2 * elu_pkg::SPEED_FRAC);
    vp = p * (128'(v) * 128'(v));
    if (kr < vp) return 0;
    dv = kr - vp;
    for (int b = 31; b >= 0; b--) begin
      c = r | (128'(1) << b);
      if (c * c <= dv) r = c;
    end
    t = 128'(v) * 128'(64'(mx) * 64'(k) - sum);
    if (!(t < r || (t == r && r * r != dv))) return 0;
    q = (128'(v) * 128'(sum) + r) / (128'(v) * 128'(k));
    root = (q > 128'(VMAX)) ? VMAX : q[VB-1:0];
    return 1;
  endfunction

  function automatic upd_t cell_update(input cell_t c);
    logic [VB-1:0] s [3];
    logic [VB-1:0] best, tmin, root;
    bit   act [3];
    int   n, mi;
    upd_t u;
    n = 0;
    best = c.cur;
    for (int i = 0; i < 3; i++) begin
      tmin = (c.nb[2*i] < c.nb[2*i+1]) ? c.nb[2*i] : c.nb[2*i+1];
      s[i] = tmin;
      act[i] = tmin < c.cur;
      if (act[i]) n++;
    end
    for (int cnt = n; cnt > 0; cnt--) begin
      mi = 3;
      for (int i = 0; i < 3; i++)
        if (act[i] && (mi == 3 || s[i] > s[mi])) mi = i;
      if (upwind_root(s, act, cnt, s[mi], c.v, root) && root < best) best = root;
      act[mi] = 0;
    end
    u.new_value = best;
    u.improved = best < c.cur;
    u.axes = n[1:0];
    return u;
  endfunction

  function automatic cell_t mk_cell(input logic [31:0] cur, input logic [31:0] mx,
                                    input logic [31:0] px, input logic [31:0] my,
                                    input logic [31:0] py, input logic [31:0] mz,
                                    input logic [31:0] pz, input logic [15:0] v);
    cell_t c;
    c.cur = cur;
    c.nb = '{mx, px, my, py, mz, pz};
    c.v = v;
    return c;
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    logic [31:0] base;
    int spread;
    if ($urandom_range(0, 9) < 3) begin
      c.cur = $urandom;
      foreach (c.nb[i]) c.nb[i] = $urandom;
      c.v = 16'($urandom_range(1, 65535));
      if ($urandom_range(0, 7) == 0) c.cur = VMAX;
    end else begin
      // clustered times so several axes are active and roots compete
      spread = 1 << $urandom_range(8, 19);
      base = $urandom_range(0, 32'h4000_0000);
      c.cur = ($urandom_range(0, 3) == 0) ? VMAX : base + $urandom_range(0, 4 * spread);
      foreach (c.nb[i]) begin
        c.nb[i] = base + $urandom_range(0, 2 * spread);
        if ($urandom_range(0, 9) == 0) c.nb[i] = VMAX;
      end
      c.v = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) :
                                          16'($urandom_range(16, 4096));
    end
    return c;
  endfunction

  task automatic add_row(input cell_t c, input bit typed, input upd_t r);
    row_t w;
    w.c = c;
    w.typed = typed;
    w.r = r;
    rows.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, checked);
  endtask

  task automatic send_word(input cell_t c, input upd_t u);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
    in_cur = c.cur;
    in_nb = c.nb;
    in_speed = c.v;
    drive_upd = u;
    start = 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle <= 0;
      else idle <= idle + 1;
      if (start && !busy) begin
        pending_upd.push_back(drive_upd);
        accepted <= accepted + 1;
      end
      if (out_valid) begin
        checked <= checked + 1;
        if (pending_upd.size() == 0) begin
          report_mismatch("unexpected result word", 64'(out_new_value), 64'(0));
        end else begin
          upd_t e;
          e = pending_upd.pop_front();
          if (out_new_value !== e.new_value) report_mismatch("new_value", out_new_value,
                                                             e.new_value);
          if (out_improved !== e.improved) report_mismatch("improved", out_improved,
                                                           e.improved);
          if (out_active_axes !== e.axes) report_mismatch("active_axes", out_active_axes,
                                                          e.axes);
          if (out_improved) improved_seen++;
          axes_seen[out_active_axes]++;
        end
      end
      if (idle >= IDLE_LIMIT) begin
        $display("watchdog: no progress, %0d results outstanding", pending_upd.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    upd_t none;
    cell_t c;
    none = '0;
    // no axis below the current time: passes through
    add_row(mk_cell(0, 0, 0, 0, 0, 0, 0, 16'h0100), 1, '{32'h0, 1'b0, 2'd0});
    add_row(mk_cell(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 16'hFFFF), 1,
            '{VMAX, 1'b0, 2'd0});
    add_row(mk_cell(32'h0002_0000, 32'h0002_0000, 32'h0003_0000, 32'h0002_0000,
                    VMAX, 32'h0002_0000, 32'h0002_0000, 16'h0001), 1,
            '{32'h0002_0000, 1'b0, 2'd0});
    // single axis at zero, unit speed: one grid step
    add_row(mk_cell(VMAX, 0, VMAX, VMAX, VMAX, VMAX, VMAX, 16'h0100), 1,
            '{32'h0001_0000, 1'b1, 2'd1});
    // zero speed: root saturates
    add_row(mk_cell(VMAX, 0, 0, 0, 0, 0, 0, 16'h0000), 1, '{VMAX, 1'b0, 2'd3});
    add_row(mk_cell(32'h0005_0000, 0, 32'h0001_0000, VMAX, VMAX, 0, 0, 16'h0000),
            1, '{32'h0005_0000, 1'b0, 2'd2});
    add_row(mk_cell(VMAX, 0, 0, 0, 0, 0, 0, 16'h0100), 0, none);
    add_row(mk_cell(VMAX, 0, 0, 0, 0, 0, 0, 16'h0001), 0, none);
    add_row(mk_cell(VMAX, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, none);
    add_row(mk_cell(VMAX, 0, 5, 32'h0000_8000, 7, 32'h0001_0000, 9, 16'h0100), 0, none);
    add_row(mk_cell(VMAX, 0, 1, 32'h0010_0000, 3, 32'h0030_0000, 5, 16'h0100), 0, none);
    // ties for the largest time
    add_row(mk_cell(VMAX, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                    32'h0001_0000, 32'h0004_0000, 16'h0100), 0, none);
    add_row(mk_cell(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                    32'h0002_0000, 32'h0003_0000, 32'h0003_0000, 16'h0080), 0, none);
    add_row(mk_cell(VMAX, 32'hFFFF_FFFE, VMAX, 32'hFFFF_FFFE, VMAX,
                    32'hFFFF_FFFE, VMAX, 16'h0100), 0, none);
    add_row(mk_cell(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_0000, 32'hAAAA_AAAA,
                    32'h5555_5555, 32'h1234_5678, 32'h8765_4321, 16'h0001), 0, none);
    add_row(mk_cell(32'h0001_0000, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF,
                    32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 16'hFFFF), 0, none);
    add_row(mk_cell(VMAX, 0, 0, 32'h0100_0000, 32'h0100_0000, VMAX, VMAX,
                    16'h8000), 0, none);

    repeat (11) @(negedge clk);
    rst_n = 1;
    foreach (rows[i])
      send_word(rows[i].c, rows[i].typed ? rows[i].r : cell_update(rows[i].c));
    for (int i = 0; i < N_RANDOM; i++) begin
      c = rand_cell();
      send_word(c, cell_update(c));
    end
    start = 0;
    while (pending_upd.size() != 0) @(negedge clk);
    repeat (elu_pkg::LATENCY + 10) @(negedge clk);
    $display("%0d cells updated, %0d improved; active axes 0/1/2/3: %0d/%0d/%0d/%0d",
             checked, improved_seen, axes_seen[0], axes_seen[1], axes_seen[2], axes_seen[3]);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/elu_pkg.sv
rtl/elu_isqrt.sv
rtl/elu_div.sv
rtl/eikonal_local_update_unit.sv
verif/eikonal_local_update_unit_tb.sv
